// ===== hdl/sfa_pkg.sv =====
// shared constants for the single-precision adder pipeline
// no dependencies
`default_nettype none
package sfa_pkg;
    localparam int unsigned DataWidth = 32;
    localparam int unsigned ExpWidth  = 8;
    localparam int unsigned MantWidth = 23;
    localparam logic [7:0]  ExpAllOnes = 8'hFF;
    localparam logic [31:0] DefaultNan = 32'h7FC0_0000;
    localparam logic [31:0] QuietBit   = 32'h0040_0000;
    localparam int unsigned PipeDepth  = 4;
endpackage
`default_nettype wire

// ===== hdl/single_float_adder.sv =====
// single-precision float adder, four register stages with a skid-free stall
// depends on sfa_pkg
`default_nettype none
// usage:
//   slave channel: one beat carries operand_a (tdata[31:0]) and operand_b
//   (tdata[63:32]); master channel: one beat carries sum_bits (tdata[31:0])
//   an accepted beat passes through the unpack/align, add, normalize and
//   round/pack registers before its result reaches the master side
//   throughput: one beat per cycle unless the receiver stalls; every stage
//   is a register with a valid bit, set by unpack/align, add, normalize, round/pack
//   a stage advances when it is empty or the stage after it advances, so
//   a stalled receiver holds the last stage and backs up the pipe without
//   losing or repeating beats; s_axis_tready drops only when the pipe is full
//   and the receiver is stalled
//   reset clears all valid bits; no beat is in flight after reset
//   special operands (nan, infinity, zero) are decided in the first stage
//   and carried down as a ready result
module single_float_adder
    import sfa_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,  // operand_a[31:0], operand_b[63:32]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata   // sum_bits[31:0]
);
    // stage enables
    logic [PipeDepth-1:0] r_vld;
    logic adv1, adv2, adv3, adv4;
    assign adv4 = !r_vld[3] || m_axis_tready;
    assign adv3 = !r_vld[2] || adv4;
    assign adv2 = !r_vld[1] || adv3;
    assign adv1 = !r_vld[0] || adv2;
    assign s_axis_tready = adv1;

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (adv1) r_vld[0] <= s_axis_tvalid;
            if (adv2) r_vld[1] <= r_vld[0];
            if (adv3) r_vld[2] <= r_vld[1];
            if (adv4) r_vld[3] <= r_vld[2];
        end
    end

    // stage 1: unpack, classify, align
    logic [31:0] a, b;
    logic sa, sb;
    logic [7:0] ea, eb, ediff;
    logic [22:0] ma, mb;
    logic nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
    logic [26:0] fa, fb, big, small_in, small_sh;
    logic a_big;
    logic [4:0] sh;
    logic sticky;
    logic n1_spec;
    logic [31:0] n1_res;
    always_comb begin
        a = s_axis_tdata[31:0];
        b = s_axis_tdata[63:32];
        sa = a[31]; sb = b[31];
        ea = a[30:23]; eb = b[30:23];
        ma = a[22:0]; mb = b[22:0];
        nan_a = (ea == ExpAllOnes) && (ma != '0);
        nan_b = (eb == ExpAllOnes) && (mb != '0);
        inf_a = (ea == ExpAllOnes) && (ma == '0);
        inf_b = (eb == ExpAllOnes) && (mb == '0);
        zero_a = (ea == '0) && (ma == '0);
        zero_b = (eb == '0) && (mb == '0);
        n1_spec = 1'b1;
        n1_res = '0;
        if (nan_a)              n1_res = a | QuietBit;
        else if (nan_b)         n1_res = b | QuietBit;
        else if (inf_a && inf_b) n1_res = (sa == sb) ? a : DefaultNan;
        else if (inf_a)         n1_res = a;
        else if (inf_b)         n1_res = b;
        else if (zero_a && zero_b) n1_res = {sa & sb, 31'd0};
        else if (zero_a)        n1_res = b;
        else if (zero_b)        n1_res = a;
        else                    n1_spec = 1'b0;
        fa = {1'b1, ma, 3'b000};
        fb = {1'b1, mb, 3'b000};
        a_big = ea > eb;
        ediff = a_big ? (ea - eb) : (eb - ea);
        big = a_big ? fb : fa;          // operand that gets shifted
        small_in = big;
        sh = (ediff >= 8'd27) ? 5'd27 : ediff[4:0];
        small_sh = small_in >> sh;
        sticky = ((small_in & ~({27{1'b1}} << sh)) != '0);
        if (ediff >= 8'd27) small_sh = '0;
        small_sh[0] = small_sh[0] | sticky;
    end

    logic        r1_spec;
    logic [31:0] r1_res;
    logic [26:0] r1_x, r1_y;
    logic        r1_sx, r1_sy;
    logic [7:0]  r1_e;
    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r1_spec <= n1_spec;
            r1_res  <= n1_res;
            r1_x    <= a_big ? fa : small_sh;
            r1_y    <= a_big ? small_sh : fb;
            r1_sx   <= sa;
            r1_sy   <= sb;
            r1_e    <= a_big ? ea : eb;
        end
    end

    // stage 2: add or subtract by sign
    logic [27:0] n2_sum;
    logic        n2_s;
    always_comb begin
        n2_s = r1_sx;
        if (r1_sx == r1_sy) n2_sum = {1'b0, r1_x} + {1'b0, r1_y};
        else if (r1_x >= r1_y) n2_sum = {1'b0, r1_x - r1_y};
        else begin
            n2_sum = {1'b0, r1_y - r1_x};
            n2_s = ~r1_sx;
        end
    end
    logic        r2_spec;
    logic [31:0] r2_res;
    logic [27:0] r2_sum;
    logic        r2_s;
    logic [7:0]  r2_e;
    always_ff @(posedge i_clk) begin
        if (adv2) begin
            r2_spec <= r1_spec;
            r2_res  <= r1_res;
            r2_sum  <= n2_sum;
            r2_s    <= n2_s;
            r2_e    <= r1_e;
        end
    end

    // stage 3: normalize, leading zero count over the low 27 bits of the 28-bit sum
    logic [4:0]  lz;
    logic [26:0] n3_m;
    logic signed [9:0] n3_e;
    logic        n3_zero;
    always_comb begin
        lz = 5'd0;
        for (int i = 0; i < 27; i++) begin
            if (r2_sum[i]) lz = 5'(26 - i);
        end
        n3_zero = (r2_sum == '0);
        if (r2_sum[27]) begin
            n3_m = r2_sum[27:1] | {26'd0, r2_sum[0]};
            n3_e = $signed({2'b00, r2_e}) + 10'sd1;
        end else begin
            n3_m = r2_sum[26:0] << lz;
            n3_e = $signed({2'b00, r2_e}) - $signed({5'd0, lz});
        end
    end
    logic        r3_spec, r3_zero, r3_s;
    logic [31:0] r3_res;
    logic [26:0] r3_m;
    logic signed [9:0] r3_e;
    always_ff @(posedge i_clk) begin
        if (adv3) begin
            r3_spec <= r2_spec;
            r3_res  <= r2_res;
            r3_zero <= n3_zero;
            r3_s    <= r2_s;
            r3_m    <= n3_m;
            r3_e    <= n3_e;
        end
    end

    // stage 4: round to nearest even and pack
    logic [24:0] m24;
    logic [2:0]  low3;
    logic signed [9:0] e4;
    logic [31:0] n4_res;
    always_comb begin
        low3 = r3_m[2:0];
        m24 = {1'b0, r3_m[26:3]};
        if (low3 > 3'd4 || (low3 == 3'd4 && m24[0])) m24 = m24 + 25'd1;
        e4 = r3_e;
        if (m24[24]) begin
            m24 = m24 >> 1;
            e4 = e4 + 10'sd1;
        end
        if (r3_spec) n4_res = r3_res;
        else if (r3_zero) n4_res = '0;
        else if (e4 >= 10'sd255) n4_res = {r3_s, ExpAllOnes, 23'd0};
        else if (e4 <= 10'sd0) n4_res = '0;
        else n4_res = {r3_s, e4[7:0], m24[22:0]};
    end
    logic [31:0] r4_res;
    always_ff @(posedge i_clk) begin
        if (adv4) r4_res <= n4_res;
    end

    assign m_axis_tvalid = r_vld[3];
    assign m_axis_tdata  = r4_res;
endmodule
`default_nettype wire

// ===== test/tb_single_float_adder.sv =====
// testbench for the single-precision float adder: directed and random operand pairs,
// sums predicted in the bench and checked beat by beat; depends on sfa_pkg and the dut
`timescale 1ns / 100ps
`default_nettype none
module tb_single_float_adder;
    import sfa_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;  // operand_a[31:0], operand_b[63:32]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;  // sum_bits[31:0]

    logic [31:0] sum_queue[$];
    int unsigned mismatch_cnt;
    int unsigned sum_cnt;
    int unsigned beat_cnt;
    bit          src_idle_en;
    bit          sink_idle_en;

    single_float_adder u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 4 ns clock
    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // right shift keeping a sticky bit
    function automatic logic [31:0] shift_sticky(input logic [31:0] v, input int unsigned s);
        logic [31:0] lost;
        if (s == 0) return v;
        if (s >= 27) return (v != 0) ? 32'd1 : 32'd0;
        lost = v & ((32'd1 << s) - 32'd1);
        return (v >> s) | ((lost != 0) ? 32'd1 : 32'd0);
    endfunction

    // expected rounded sum of two single-precision patterns
    function automatic logic [31:0] float_sum(input logic [31:0] a, input logic [31:0] b);
        logic        sa, sb, rs;
        logic [7:0]  ea, eb;
        logic [22:0] ma, mb;
        logic [31:0] mx, my;
        logic [63:0] sum, m24, low3;
        int          ex;
        bit          nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
        sa = a[31]; sb = b[31];
        ea = a[30:23]; eb = b[30:23];
        ma = a[22:0]; mb = b[22:0];
        nan_a = (ea == ExpAllOnes) && (ma != 0);
        nan_b = (eb == ExpAllOnes) && (mb != 0);
        inf_a = (ea == ExpAllOnes) && (ma == 0);
        inf_b = (eb == ExpAllOnes) && (mb == 0);
        zero_a = (ea == 0) && (ma == 0);
        zero_b = (eb == 0) && (mb == 0);
        if (nan_a) return a | QuietBit;
        if (nan_b) return b | QuietBit;
        if (inf_a && inf_b) return (sa == sb) ? a : DefaultNan;
        if (inf_a) return a;
        if (inf_b) return b;
        if (zero_a && zero_b) return {sa & sb, 31'd0};
        if (zero_a) return b;
        if (zero_b) return a;
        // denormals keep the hidden one at exponent 0
        mx = {6'd0, 1'b1, ma, 3'd0};
        my = {6'd0, 1'b1, mb, 3'd0};
        if (ea > eb) begin
            my = shift_sticky(my, ea - eb);
            ex = ea;
        end else begin
            mx = shift_sticky(mx, eb - ea);
            ex = eb;
        end
        rs = sa;
        if (sa == sb) begin
            sum = 64'(mx) + 64'(my);
        end else if (mx >= my) begin
            sum = 64'(mx - my);
        end else begin
            sum = 64'(my - mx);
            rs = ~rs;
        end
        if (sum == 0) return 32'd0;
        while (sum >= (64'd1 << 27)) begin
            sum = (sum >> 1) | (sum & 64'd1);
            ex++;
        end
        while (sum < (64'd1 << 26)) begin
            sum = sum << 1;
            ex--;
        end
        // round to nearest, ties to even
        m24 = sum >> 3;
        low3 = sum & 64'd7;
        if (low3 > 4 || (low3 == 4 && m24[0])) m24++;
        if (m24 >= (64'd1 << 24)) begin
            m24 = m24 >> 1;
            ex++;
        end
        if (ex >= 255) return {rs, ExpAllOnes, 23'd0};
        if (ex <= 0) return 32'd0;
        return {rs, ex[7:0], m24[22:0]};
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_cnt++;
        $display("mismatch %s: got %08h expected %08h at %0t", what, got, want, $time);
    endtask

    // send one operand pair, with a random gap before it when enabled
    task automatic send_pair(input logic [31:0] a, input logic [31:0] b);
        if (src_idle_en && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {b, a};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sum_queue = {sum_queue, float_sum(a, b)};
        beat_cnt++;
        @(negedge i_clk);
    endtask

    task automatic pause_send();
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
    endtask

    // result checker on the master side
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (sum_queue.size() == 0) begin
                report_mismatch("unexpected beat", m_axis_tdata, 32'd0);
            end else begin
                if (m_axis_tdata !== sum_queue[0])
                    report_mismatch("sum_bits", m_axis_tdata, sum_queue[0]);
                void'(sum_queue.pop_front());
                sum_cnt++;
            end
        end
    end

    // receiver stalls in bursts
    initial begin
        int stall;
        m_axis_tready = 1'b1;
        forever begin
            @(negedge i_clk);
            if (sink_idle_en && $urandom_range(0, 7) == 0) begin
                stall = $urandom_range(1, 18);
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    function automatic logic [31:0] rand_float();
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(0, 9))
            0: v[30:23] = 8'hFF;
            1: v[30:23] = 8'h00;
            2: v[30:23] = 8'($urandom_range(250, 254));
            3: v[30:23] = 8'($urandom_range(1, 4));
            4: v[22:0] = ($urandom_range(0, 1) != 0) ? 23'd0 : 23'h7FFFFF;
            default: ;
        endcase
        return v;
    endfunction

    task automatic test_special_operands();
        send_pair(32'h7F800001, 32'h3F800000);  // signaling nan in a
        send_pair(32'h3F800000, 32'hFFC12345);  // nan in b
        send_pair(32'h7FA00000, 32'hFF800001);  // first nan wins
        send_pair(32'h7F800000, 32'h7F800000);  // inf plus inf
        send_pair(32'h7F800000, 32'hFF800000);  // inf minus inf
        send_pair(32'hFF800000, 32'h12345678);  // one infinity
        send_pair(32'h00000000, 32'h80000000);  // mixed zeros
        send_pair(32'h80000000, 32'h80000000);  // negative zeros
        send_pair(32'h00000000, 32'h00000001);  // zero plus denormal
        send_pair(32'hC0490FDB, 32'h00000000);  // operand plus zero
    endtask

    task automatic test_arithmetic_edges();
        send_pair(32'h3F800000, 32'hBF800000);  // exact cancellation
        send_pair(32'h7F7FFFFF, 32'h7F7FFFFF);  // overflow
        send_pair(32'hFF7FFFFF, 32'hFF000000);  // negative overflow
        send_pair(32'h00800000, 32'h80800001);  // underflow flush
        send_pair(32'h00000001, 32'h807FFFFF);  // denormals
        send_pair(32'h3F800000, 32'h33800000);  // tie to even
        send_pair(32'h3F800001, 32'h33800000);  // tie rounds up
        send_pair(32'h4B7FFFFF, 32'h3F000000);  // carry out of rounding
        send_pair(32'h3F800000, 32'h00000001);  // far alignment
        send_pair(32'h3F800000, 32'hBF7FFFFF);  // deep normalization
        send_pair(32'hFFFFFFFF, 32'hFFFFFFFF);  // all ones
        send_pair(32'h80000001, 32'h00000002);  // sign from larger
        pause_send();
    endtask

    task automatic test_random_pairs(input int n);
        logic [31:0] a, b;
        for (int i = 0; i < n; i++) begin
            a = rand_float();
            b = ($urandom_range(0, 4) == 0) ? (a ^ (32'h1 << $urandom_range(0, 31)))
                                              : rand_float();
            if ($urandom_range(0, 9) == 0) b = {~a[31], a[30:0]};
            send_pair(a, b);
        end
        pause_send();
    endtask

    task automatic drain_sums();
        while (sum_queue.size() != 0) @(negedge i_clk);
        repeat (PipeDepth + 4) @(negedge i_clk);
    endtask

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        mismatch_cnt = 0;
        sum_cnt = 0;
        beat_cnt = 0;
        src_idle_en = 1'b1;
        sink_idle_en = 1'b1;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);
        test_special_operands();
        test_arithmetic_edges();
        test_random_pairs(700);
        // sender holds off until the pipe is empty
        drain_sums();
        test_random_pairs(700);
        // closing stretch at full rate on both sides
        src_idle_en = 1'b0;
        sink_idle_en = 1'b0;
        @(negedge i_clk);
        test_random_pairs(280);
        drain_sums();
        $display("covered nan, infinity, zero, denormal, overflow, underflow and rounding cases");
        $display("%0d operand beats sent, %0d sums checked", beat_cnt, sum_cnt);
        if (mismatch_cnt == 0 && sum_queue.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("FAIL");
        $finish;
    end
endmodule
`default_nettype wire
